[src/hrbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response body deframer package
// Shared widths, phase and request codes, character constants and the
// small decode functions used by the deframer core.
// ----------------------------------------------------------------------------
package hrbd_pkg;

    localparam int TimeoutWidth = 20;
    localparam int LengthWidth  = 32;
    localparam int ChunkWidth   = 17;
    localparam int AccumWidth   = 16;
    localparam int LabelLen     = 16;

    localparam logic [TimeoutWidth-1:0] TIMEOUT_RESET = 20'd10000;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_START      = 2'd0;
    localparam logic [1:0] REQ_BYTE       = 2'd1;
    localparam logic [1:0] REQ_TICK       = 2'd2;
    localparam logic [1:0] REQ_DISCONNECT = 2'd3;

    // Response phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_FIXED  = 2'd2;
    localparam logic [1:0] PH_CHUNK  = 2'd3;

    // Content-Length collection status.
    localparam logic [1:0] LC_NOT_SEEN = 2'd0;
    localparam logic [1:0] LC_COLLECT  = 2'd1;
    localparam logic [1:0] LC_DONE     = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_C  = 8'h43;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } hex_digit_t;

    // Character of the "Content-Length: " label at a given position.
    function automatic logic [7:0] label_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.hit   = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.hit   = 1'b1;
            d.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d.hit   = 1'b1;
            d.value = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

[src/http_response_body_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response body deframer core
// Extracts the body of an HTTP/1.1 response, by Content-Length or by chunked
// transfer decoding, and reports success, disconnect or idle timeout.
// ----------------------------------------------------------------------------
// Every input beat (start, received byte, time tick or disconnect) produces
// exactly one result beat. The block accepts one beat per clock cycle while
// the result side is not stalled: the parser state and the result register
// are both updated at the accepting edge, and the result appears on the m_
// side in the next cycle. A new input beat is accepted whenever the result
// register is empty or is being taken in the same cycle, so with m_ready
// held high the throughput is one beat per cycle. The idle timeout limit is
// written through the cfg_ port, which is always ready; it should only be
// changed while no response is in progress. The end_of_packet flag is
// carried for framing information only and does not affect parsing.
// ----------------------------------------------------------------------------
module http_response_body_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_byte_value,
    input  logic        s_end_of_packet,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_finished,
    output logic        m_succeeded
);

    // Configuration: the idle timeout limit.
    logic [hrbd_pkg::TimeoutWidth-1:0] timeout_reg;

    // Parser state.
    logic [1:0]                          phase_reg,          phase_next;
    logic [2:0]                          line_end_run_reg,   line_end_run_next;
    logic [4:0]                          pattern_pos_reg,    pattern_pos_next;
    logic [1:0]                          length_collect_reg, length_collect_next;
    logic [hrbd_pkg::LengthWidth-1:0]    body_length_reg,    body_length_next;
    logic [hrbd_pkg::LengthWidth-1:0]    body_count_reg,     body_count_next;
    logic [hrbd_pkg::ChunkWidth-1:0]     chunk_left_reg,     chunk_left_next;
    logic [1:0]                          size_line_run_reg,  size_line_run_next;
    logic [hrbd_pkg::AccumWidth-1:0]     size_accum_reg,     size_accum_next;
    logic [hrbd_pkg::TimeoutWidth-1:0]   idle_count_reg,     idle_count_next;

    // Result register.
    logic       m_valid_reg,         m_valid_next;
    logic       payload_valid_reg,   payload_valid_next;
    logic [7:0] payload_byte_reg,    payload_byte_next;
    logic       finished_reg,        finished_next;
    logic       succeeded_reg,       succeeded_next;

    logic                in_fire;
    logic [7:0]          c;
    hrbd_pkg::hex_digit_t hex;
    logic [35:0]         length_product;
    logic [4:0]          pattern_step;

    // The result register is the only buffer: take a new beat when it is
    // empty or being drained.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign c   = s_byte_value;
    assign hex = hrbd_pkg::hex_decode(c);

    // Decimal accumulate, body_length * 10 + digit, built from two shifts.
    assign length_product = {1'b0, body_length_reg, 3'b000}
                          + {3'b000, body_length_reg, 1'b0}
                          + {32'd0, c[3:0]};

    always_comb begin
        phase_next          = phase_reg;
        line_end_run_next   = line_end_run_reg;
        pattern_pos_next    = pattern_pos_reg;
        length_collect_next = length_collect_reg;
        body_length_next    = body_length_reg;
        body_count_next     = body_count_reg;
        chunk_left_next     = chunk_left_reg;
        size_line_run_next  = size_line_run_reg;
        size_accum_next     = size_accum_reg;
        idle_count_next     = idle_count_reg;
        payload_valid_next  = 1'b0;
        payload_byte_next   = 8'd0;
        finished_next       = 1'b0;
        succeeded_next      = 1'b0;
        pattern_step        = 5'd0;

        if (s_req_type == hrbd_pkg::REQ_START) begin
            // A start always restarts parsing, even in the middle of a response.
            phase_next          = hrbd_pkg::PH_HEADER;
            line_end_run_next   = 3'd0;
            pattern_pos_next    = 5'd0;
            length_collect_next = hrbd_pkg::LC_NOT_SEEN;
            body_length_next    = '0;
            body_count_next     = '0;
            chunk_left_next     = '0;
            size_line_run_next  = 2'd0;
            size_accum_next     = '0;
            idle_count_next     = '0;
        end else if (phase_reg != hrbd_pkg::PH_IDLE) begin
            unique case (s_req_type)
                hrbd_pkg::REQ_DISCONNECT: begin
                    phase_next    = hrbd_pkg::PH_IDLE;
                    finished_next = 1'b1;
                end
                hrbd_pkg::REQ_TICK: begin
                    if (idle_count_reg >= timeout_reg) begin
                        phase_next    = hrbd_pkg::PH_IDLE;
                        finished_next = 1'b1;
                    end else begin
                        idle_count_next = idle_count_reg + 20'd1;
                    end
                end
                default: begin
                    idle_count_next = '0;
                    unique case (phase_reg)
                        hrbd_pkg::PH_HEADER: begin
                            // Content-Length label match and digit collection.
                            if (length_collect_reg == hrbd_pkg::LC_COLLECT) begin
                                if (hrbd_pkg::is_decimal(c)) begin
                                    if (length_product[35:32] != 4'd0) begin
                                        body_length_next = '1;
                                    end else begin
                                        body_length_next = length_product[31:0];
                                    end
                                end else begin
                                    length_collect_next = hrbd_pkg::LC_DONE;
                                end
                            end else if (length_collect_reg == hrbd_pkg::LC_NOT_SEEN) begin
                                if (c == hrbd_pkg::label_char(pattern_pos_reg[3:0])) begin
                                    pattern_step = pattern_pos_reg + 5'd1;
                                end else if (c == hrbd_pkg::CHAR_C) begin
                                    pattern_step = 5'd1;
                                end else begin
                                    pattern_step = 5'd0;
                                end
                                if (pattern_step == 5'(hrbd_pkg::LabelLen)) begin
                                    pattern_pos_next    = 5'd0;
                                    length_collect_next = hrbd_pkg::LC_COLLECT;
                                    body_length_next    = '0;
                                end else begin
                                    pattern_pos_next = pattern_step;
                                end
                            end

                            // Four line-end characters in a row close the header.
                            if (hrbd_pkg::is_line_end(c)) begin
                                line_end_run_next = line_end_run_reg + 3'd1;
                            end else begin
                                line_end_run_next = 3'd0;
                            end
                            if (line_end_run_next >= 3'd4) begin
                                line_end_run_next = 3'd4;
                                if (length_collect_next != hrbd_pkg::LC_NOT_SEEN &&
                                    body_length_next != '0) begin
                                    phase_next      = hrbd_pkg::PH_FIXED;
                                    body_count_next = '0;
                                end else begin
                                    phase_next         = hrbd_pkg::PH_CHUNK;
                                    chunk_left_next    = '0;
                                    size_line_run_next = 2'd0;
                                    size_accum_next    = '0;
                                end
                            end
                        end
                        hrbd_pkg::PH_FIXED: begin
                            payload_valid_next = 1'b1;
                            payload_byte_next  = c;
                            body_count_next    = body_count_reg + 32'd1;
                            if (body_count_next >= body_length_reg) begin
                                phase_next     = hrbd_pkg::PH_IDLE;
                                finished_next  = 1'b1;
                                succeeded_next = 1'b1;
                            end
                        end
                        default: begin
                            if (chunk_left_reg == '0) begin
                                // Size line: hex digits, ended by two line-end characters in a row.
                                if (hrbd_pkg::is_line_end(c)) begin
                                    size_line_run_next = size_line_run_reg + 2'd1;
                                end else begin
                                    size_line_run_next = 2'd0;
                                    if (hex.hit) begin
                                        size_accum_next = {size_accum_reg[11:0], hex.value};
                                    end
                                end
                                if (size_line_run_next >= 2'd2) begin
                                    size_line_run_next = 2'd0;
                                    size_accum_next    = '0;
                                    if (size_accum_reg == '0) begin
                                        phase_next     = hrbd_pkg::PH_IDLE;
                                        finished_next  = 1'b1;
                                        succeeded_next = 1'b1;
                                    end else begin
                                        chunk_left_next = {1'b0, size_accum_reg} + 17'd2;
                                    end
                                end
                            end else begin
                                // Chunk data; the last two bytes are the CRLF trailer.
                                if (chunk_left_reg > 17'd2) begin
                                    payload_valid_next = 1'b1;
                                    payload_byte_next  = c;
                                end
                                chunk_left_next = chunk_left_reg - 17'd1;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg        <= hrbd_pkg::TIMEOUT_RESET;
            phase_reg          <= hrbd_pkg::PH_IDLE;
            line_end_run_reg   <= 3'd0;
            pattern_pos_reg    <= 5'd0;
            length_collect_reg <= hrbd_pkg::LC_NOT_SEEN;
            body_length_reg    <= '0;
            body_count_reg     <= '0;
            chunk_left_reg     <= '0;
            size_line_run_reg  <= 2'd0;
            size_accum_reg     <= '0;
            idle_count_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                phase_reg          <= phase_next;
                line_end_run_reg   <= line_end_run_next;
                pattern_pos_reg    <= pattern_pos_next;
                length_collect_reg <= length_collect_next;
                body_length_reg    <= body_length_next;
                body_count_reg     <= body_count_next;
                chunk_left_reg     <= chunk_left_next;
                size_line_run_reg  <= size_line_run_next;
                size_accum_reg     <= size_accum_next;
                idle_count_reg     <= idle_count_next;
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            payload_valid_reg <= payload_valid_next;
            payload_byte_reg  <= payload_byte_next;
            finished_reg      <= finished_next;
            succeeded_reg     <= succeeded_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_valid = payload_valid_reg;
    assign m_payload_byte  = payload_byte_reg;
    assign m_finished      = finished_reg;
    assign m_succeeded     = succeeded_reg;

    // An accepted beat always produces a result beat on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid)
        else $error("accepted beat produced no result");

    // Success is only ever reported together with the end of a response.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_succeeded |-> m_finished)
        else $error("success reported without finish");

    // A result without a body byte carries a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload_valid |-> m_payload_byte == 8'd0)
        else $error("stale payload byte on a non-payload result");

    // The header line-end run never exceeds four and a size line never
    // holds two line ends in a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        line_end_run_reg <= 3'd4 && size_line_run_reg < 2'd2)
        else $error("line-end run counters out of range");

    // A finishing result always leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && finished_next |=> phase_reg == hrbd_pkg::PH_IDLE)
        else $error("response finished but phase not idle");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response body deframer core testbench
// Streams start, byte, tick and disconnect beats into the core, predicts every
// result beat with an independent model of the response parser, and compares
// the result channel field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    // Limit on the whole run, far above the slowest legal run.
    localparam int CycleLimit   = 400000;
    // Cycles left to pass once nothing is expected any more.
    localparam int SettleCycles = 8;

    // One result beat as the core presents it.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       finished;
        logic       succeeded;
    } body_beat_t;

    // Header shapes that the traffic generator can build.
    typedef enum int {
        HDR_BARE,
        HDR_DECOY,
        HDR_ZERO,
        HDR_NO_DIGITS,
        HDR_LENGTH,
        HDR_TWICE,
        HDR_HUGE
    } header_style_t;

    // Which header shapes a traffic run draws from.
    typedef enum int {
        MIX_FIXED,
        MIX_CHUNKED,
        MIX_ANY
    } traffic_mix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = hrbd_pkg::REQ_TICK;
    logic [7:0]  s_byte_value = '0;
    logic        s_end_of_packet = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic        m_finished;
    logic        m_succeeded;

    http_response_body_deframer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_byte_value    (s_byte_value),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_finished      (m_finished),
        .m_succeeded     (m_succeeded)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Parser model state. These mirror what the core must track: the response
    // phase, header scanning for the length label, the fixed body count, the
    // chunk framing and the idle tick counter.
    // ------------------------------------------------------------------------
    logic [1:0]                        rsp_phase = hrbd_pkg::PH_IDLE;
    logic [2:0]                        crlf_run = '0;
    logic [4:0]                        label_pos = '0;
    logic [1:0]                        len_state = hrbd_pkg::LC_NOT_SEEN;
    logic [hrbd_pkg::LengthWidth-1:0]  content_length = '0;
    logic [hrbd_pkg::LengthWidth-1:0]  body_seen = '0;
    logic [hrbd_pkg::ChunkWidth-1:0]   chunk_left = '0;
    logic [1:0]                        size_run = '0;
    logic [hrbd_pkg::AccumWidth-1:0]   size_accum = '0;
    logic [hrbd_pkg::TimeoutWidth-1:0] idle_ticks = '0;
    logic [hrbd_pkg::TimeoutWidth-1:0] timeout_limit = hrbd_pkg::TIMEOUT_RESET;

    // The label exactly as it must appear, case included.
    localparam logic [8*hrbd_pkg::LabelLen-1:0] LengthLabel = "Content-Length: ";
    string length_label = "Content-Length: ";

    body_beat_t expected_beats[$];
    body_beat_t oldest_beat;
    int         mismatches = 0;
    int         beats_sent = 0;
    int         cycle_count = 0;

    // Traffic shaping knobs, changed by the test tasks as they go.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;
    int tick_rate = 0;
    int tick_burst = 1;

    function automatic logic [7:0] label_at(input logic [4:0] pos);
        return LengthLabel[8*(hrbd_pkg::LabelLen-1-pos) +: 8];
    endfunction

    function automatic bit is_crlf(input logic [7:0] ch);
        return (ch == hrbd_pkg::CHAR_CR) || (ch == hrbd_pkg::CHAR_LF);
    endfunction

    // Value of a hex digit, or -1 for any other character.
    function automatic int hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return int'(ch) - int'("0");
        end
        if (ch >= "a" && ch <= "f") begin
            return int'(ch) - int'("a") + 10;
        end
        if (ch >= "A" && ch <= "F") begin
            return int'(ch) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic void reset_parse();
        crlf_run       = '0;
        label_pos      = '0;
        len_state      = hrbd_pkg::LC_NOT_SEEN;
        content_length = '0;
        body_seen      = '0;
        chunk_left     = '0;
        size_run       = '0;
        size_accum     = '0;
        idle_ticks     = '0;
    endfunction

    // One header byte: label matching, length digits and the end-of-header run.
    function automatic void scan_header(input logic [7:0] ch);
        logic [63:0] wide;
        if (len_state == hrbd_pkg::LC_COLLECT) begin
            if (ch >= "0" && ch <= "9") begin
                wide = {32'd0, content_length};
                wide = wide * 64'd10 + {56'd0, ch - 8'h30};
                content_length = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
            end else begin
                len_state = hrbd_pkg::LC_DONE;
            end
        end else if (len_state == hrbd_pkg::LC_NOT_SEEN) begin
            // A mismatch on a 'C' counts as the first label character again.
            if (label_pos < hrbd_pkg::LabelLen && ch == label_at(label_pos)) begin
                label_pos = label_pos + 5'd1;
            end else begin
                label_pos = (ch == hrbd_pkg::CHAR_C) ? 5'd1 : 5'd0;
            end
            if (label_pos >= hrbd_pkg::LabelLen) begin
                label_pos      = '0;
                len_state      = hrbd_pkg::LC_COLLECT;
                content_length = '0;
            end
        end
        crlf_run = is_crlf(ch) ? crlf_run + 3'd1 : 3'd0;
        if (crlf_run >= 3'd4) begin
            crlf_run = 3'd4;
            if (len_state != hrbd_pkg::LC_NOT_SEEN && content_length != 0) begin
                rsp_phase = hrbd_pkg::PH_FIXED;
                body_seen = '0;
            end else begin
                rsp_phase  = hrbd_pkg::PH_CHUNK;
                chunk_left = '0;
                size_run   = '0;
                size_accum = '0;
            end
        end
    endfunction

    // Advances the model by one accepted input beat and returns its result.
    function automatic body_beat_t predict_beat(input logic [1:0] req,
                                                input logic [7:0] ch);
        body_beat_t res;
        int         nib;
        res = '0;
        if (req == hrbd_pkg::REQ_START) begin
            rsp_phase = hrbd_pkg::PH_HEADER;
            reset_parse();
        end else if (rsp_phase != hrbd_pkg::PH_IDLE) begin
            if (req == hrbd_pkg::REQ_DISCONNECT) begin
                rsp_phase    = hrbd_pkg::PH_IDLE;
                res.finished = 1'b1;
            end else if (req == hrbd_pkg::REQ_TICK) begin
                if (idle_ticks >= timeout_limit) begin
                    rsp_phase    = hrbd_pkg::PH_IDLE;
                    res.finished = 1'b1;
                end else begin
                    idle_ticks = idle_ticks + 20'd1;
                end
            end else begin
                idle_ticks = '0;
                if (rsp_phase == hrbd_pkg::PH_HEADER) begin
                    scan_header(ch);
                end else if (rsp_phase == hrbd_pkg::PH_FIXED) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = ch;
                    body_seen = body_seen + 32'd1;
                    if (body_seen >= content_length) begin
                        rsp_phase     = hrbd_pkg::PH_IDLE;
                        res.finished  = 1'b1;
                        res.succeeded = 1'b1;
                    end
                end else if (chunk_left == 0) begin
                    // Size line: hex digits accumulate, anything else is skipped.
                    if (is_crlf(ch)) begin
                        size_run = size_run + 2'd1;
                    end else begin
                        nib = hex_nibble(ch);
                        size_run = '0;
                        if (nib >= 0) begin
                            size_accum = {size_accum[hrbd_pkg::AccumWidth-5:0], nib[3:0]};
                        end
                    end
                    if (size_run >= 2'd2) begin
                        size_run = '0;
                        if (size_accum == 0) begin
                            rsp_phase     = hrbd_pkg::PH_IDLE;
                            res.finished  = 1'b1;
                            res.succeeded = 1'b1;
                        end else begin
                            chunk_left = {1'b0, size_accum} + 17'd2;
                        end
                        size_accum = '0;
                    end
                end else begin
                    // The last two bytes of a chunk are its dropped line end.
                    if (chunk_left > 17'd2) begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = ch;
                    end
                    chunk_left = chunk_left - 17'd1;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Valid rises with the payload at a clock edge and stays up
    // until the beat is taken; the gap after a beat decides whether it drops.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (tx_steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 20);
    endfunction

    task automatic send_beat(input logic [1:0] req, input logic [7:0] ch);
        int gap;
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_byte_value    <= ch;
        s_end_of_packet <= 1'($urandom_range(0, 1));
        do @(posedge aclk); while (!s_ready);
        // Beats that the idle core ignores do not count toward the item budget.
        if (req == hrbd_pkg::REQ_START || rsp_phase != hrbd_pkg::PH_IDLE) begin
            beats_sent++;
        end
        expected_beats.push_back(predict_beat(req, ch));
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drops valid and waits until every predicted result beat has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [19:0] ticks);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        timeout_limit = ticks;
        cfg_valid <= 1'b0;
    endtask

    // Sometimes slips a burst of time ticks in front of the next byte.
    task automatic maybe_ticks();
        int n;
        if (tick_rate != 0 && rsp_phase != hrbd_pkg::PH_IDLE &&
            $urandom_range(0, 99) < tick_rate) begin
            n = $urandom_range(1, tick_burst);
            repeat (n) begin
                if (rsp_phase != hrbd_pkg::PH_IDLE) begin
                    send_beat(hrbd_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] ch);
        maybe_ticks();
        send_beat(hrbd_pkg::REQ_BYTE, ch);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i]);
        end
    endtask

    task automatic send_crlf();
        send_byte(hrbd_pkg::CHAR_CR);
        send_byte(hrbd_pkg::CHAR_LF);
    endtask

    // Any mix of CR and LF counts toward a line end run.
    task automatic send_line_ends(input int n);
        repeat (n) send_byte($urandom_range(0, 1) ? hrbd_pkg::CHAR_CR : hrbd_pkg::CHAR_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) begin
            return "0" + v;
        end
        return (upper ? "A" : "a") + v - 4'd10;
    endfunction

    task automatic send_size_line(input int chunk_bytes);
        bit upper;
        int digits;
        upper = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) begin
            // Overlong size: the leading digits are shifted out of 16 bits.
            repeat (4) send_byte(hex_char(4'($urandom_range(1, 15)), upper));
            digits = 4;
        end else begin
            digits = ((chunk_bytes > 15) ? 2 : 1) + $urandom_range(0, 1);
        end
        for (int d = digits - 1; d >= 0; d--) begin
            send_byte(hex_char(4'((chunk_bytes >> (4 * d)) & 15), upper));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_text("; q");
        end
        send_line_ends(2);
    endtask

    // Payload of the open chunk, sized from the model, then its line end.
    task automatic send_chunk_data();
        logic [7:0] ch;
        while (rsp_phase == hrbd_pkg::PH_CHUNK && chunk_left != 0) begin
            if ($urandom_range(0, 59) == 0) begin
                send_beat(hrbd_pkg::REQ_DISCONNECT, 8'($urandom_range(0, 255)));
                return;
            end
            if (chunk_left > 2 || $urandom_range(0, 9) == 0) begin
                ch = 8'($urandom_range(0, 255));
            end else begin
                ch = (chunk_left == 2) ? hrbd_pkg::CHAR_CR : hrbd_pkg::CHAR_LF;
            end
            send_byte(ch);
        end
    endtask

    task automatic send_chunks();
        int count;
        count = $urandom_range(0, 4);
        for (int k = 0; k < count && rsp_phase == hrbd_pkg::PH_CHUNK; k++) begin
            send_size_line(($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                       : $urandom_range(1, 16));
            send_chunk_data();
        end
        if (rsp_phase == hrbd_pkg::PH_CHUNK) begin
            // Last chunk: a zero size, possibly spelled oddly, or an empty line.
            case ($urandom_range(0, 3))
                0: send_text("0");
                1: ;
                2: send_text("00;z");
                default: send_text("g0 ");
            endcase
            send_line_ends(2);
        end
    endtask

    task automatic send_fixed_body();
        logic [31:0] remaining;
        int          n;
        bit          cut;
        remaining = content_length - body_seen;
        if (remaining > 48) begin
            n   = $urandom_range(2, 8);
            cut = 1'b1;
        end else begin
            cut = ($urandom_range(0, 7) == 0);
            n   = cut ? $urandom_range(0, remaining - 1) : remaining;
        end
        for (int i = 0; i < n && rsp_phase == hrbd_pkg::PH_FIXED; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        // A cut body either drops the link or is abandoned by the next start.
        if (cut && rsp_phase != hrbd_pkg::PH_IDLE && $urandom_range(0, 1)) begin
            send_beat(hrbd_pkg::REQ_DISCONNECT, 8'($urandom_range(0, 255)));
        end
    endtask

    function automatic string length_digits();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
        return ($urandom_range(0, 4) == 0) ? {"00", $sformatf("%0d", len)}
                                           : $sformatf("%0d", len);
    endfunction

    task automatic send_response(input header_style_t style);
        bit first_line;
        send_beat(hrbd_pkg::REQ_START, 8'($urandom_range(0, 255)));
        first_line = $urandom_range(0, 1);
        if (first_line) begin
            send_text("X: 1");
            if (style != HDR_BARE) begin
                send_crlf();
            end
        end
        case (style)
            HDR_BARE: ;
            HDR_DECOY: begin
                // Near misses: wrong word, wrong case, cut short.
                send_text("Content-Type: a");
                send_crlf();
                send_text("content-length: 5");
                send_crlf();
                send_text("Content-Lengt");
            end
            HDR_ZERO: begin
                send_text(length_label);
                send_text("0");
            end
            HDR_NO_DIGITS: begin
                send_text(length_label);
                send_text("x");
            end
            HDR_LENGTH: begin
                if ($urandom_range(0, 3) == 0) begin
                    send_text("C");
                end
                send_text(length_label);
                send_text(length_digits());
            end
            HDR_TWICE: begin
                send_text(length_label);
                send_text(length_digits());
                send_crlf();
                send_text(length_label);
                send_text(length_digits());
            end
            default: begin
                send_text(length_label);
                case ($urandom_range(0, 2))
                    0: send_text("4294967295");
                    1: send_text("4294967296");
                    default: send_text("99999999999");
                endcase
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            send_crlf();
            send_text("Y: z");
        end
        send_line_ends(4);
        if (rsp_phase == hrbd_pkg::PH_FIXED) begin
            send_fixed_body();
        end else if (rsp_phase == hrbd_pkg::PH_CHUNK) begin
            send_chunks();
        end
        // Stray beats after the end must be ignored.
        if (rsp_phase == hrbd_pkg::PH_IDLE && $urandom_range(0, 3) == 0) begin
            send_beat(2'($urandom_range(hrbd_pkg::REQ_BYTE, hrbd_pkg::REQ_DISCONNECT)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_noise(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_beat(hrbd_pkg::REQ_BYTE,
                          ($urandom_range(0, 3) == 0)
                          ? ($urandom_range(0, 1) ? hrbd_pkg::CHAR_CR : hrbd_pkg::CHAR_LF)
                          : 8'($urandom_range(0, 255)));
            end else if (r < 80) begin
                send_beat(hrbd_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                send_beat(hrbd_pkg::REQ_DISCONNECT, 8'($urandom_range(0, 255)));
            end else begin
                send_beat(hrbd_pkg::REQ_START, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    function automatic header_style_t pick_style(input traffic_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FIXED:   return (r < 70) ? HDR_LENGTH : (r < 85) ? HDR_TWICE : HDR_HUGE;
            MIX_CHUNKED: return header_style_t'($urandom_range(HDR_BARE, HDR_NO_DIGITS));
            default:     return header_style_t'($urandom_range(HDR_BARE, HDR_HUGE));
        endcase
    endfunction

    // Runs whole responses, with some noise, until the item quota is spent.
    task automatic run_traffic(input int quota, input traffic_mix_t mix, input int noise_pct);
        int stop_at;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < noise_pct) begin
                send_noise($urandom_range(1, 6));
            end else begin
                send_response(pick_style(mix));
            end
            // Now and then the sender holds off until the core has caught up.
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bytes, ticks and disconnects before any start produce empty results.
    task automatic test_requests_while_idle();
        send_beat(hrbd_pkg::REQ_BYTE, 8'hFF);
        send_beat(hrbd_pkg::REQ_TICK, 8'h00);
        send_beat(hrbd_pkg::REQ_DISCONNECT, 8'h55);
    endtask

    // Empty header, one two-byte chunk of extreme bytes, then an empty size
    // line that closes the body with success. A byte after the end is ignored.
    task automatic test_minimal_chunked();
        send_beat(hrbd_pkg::REQ_START, 8'h00);
        send_crlf();
        send_crlf();
        send_text("2");
        send_crlf();
        send_beat(hrbd_pkg::REQ_BYTE, 8'h00);
        send_beat(hrbd_pkg::REQ_BYTE, 8'hFF);
        send_crlf();
        send_crlf();
        send_beat(hrbd_pkg::REQ_BYTE, 8'hAA);
    endtask

    // A zero limit fails on the first tick; with a limit of one, a byte clears
    // the idle count and the second tick after it fails. Then a plain drop.
    task automatic test_disconnect_and_timeout();
        write_timeout(20'd0);
        send_beat(hrbd_pkg::REQ_START, 8'h00);
        send_beat(hrbd_pkg::REQ_TICK, 8'h00);
        write_timeout(20'd1);
        send_beat(hrbd_pkg::REQ_START, 8'h00);
        send_beat(hrbd_pkg::REQ_TICK, 8'h00);
        send_beat(hrbd_pkg::REQ_BYTE, "Z");
        send_beat(hrbd_pkg::REQ_TICK, 8'h00);
        send_beat(hrbd_pkg::REQ_TICK, 8'h00);
        send_beat(hrbd_pkg::REQ_START, 8'h00);
        send_beat(hrbd_pkg::REQ_DISCONNECT, 8'h00);
    endtask

    // Content-Length bodies, including a saturated length and a repeated label,
    // with the largest idle limit so that ticks never end a response.
    task automatic test_fixed_length_bodies();
        write_timeout(20'hFFFFF);
        tick_rate  = 10;
        tick_burst = 6;
        run_traffic(300, MIX_FIXED, 0);
    endtask

    task automatic test_chunked_bodies();
        write_timeout(20'($urandom_range(100, 5000)));
        tick_rate  = 10;
        tick_burst = 6;
        run_traffic(300, MIX_CHUNKED, 0);
    endtask

    // Small idle limits with heavy tick traffic, so responses often time out.
    task automatic test_idle_timeouts();
        int limits[4];
        limits = '{1, 2, 4, 0};
        limits[3] = $urandom_range(5, 12);
        foreach (limits[i]) begin
            write_timeout(20'(limits[i]));
            tick_rate  = 25;
            tick_burst = limits[i] + 2;
            run_traffic(60, MIX_ANY, 0);
        end
    endtask

    // Every header shape plus loose beats, including starts in mid-response.
    task automatic test_mixed_traffic();
        write_timeout(20'($urandom_range(1, 20'hFFFFF)));
        tick_rate  = 15;
        tick_burst = 3;
        run_traffic(260, MIX_ANY, 25);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, and a check of each beat as it is taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
            m_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0h %0h %0h %0h",
                         $time, m_payload_valid, m_payload_byte, m_finished, m_succeeded);
                mismatches++;
            end else begin
                oldest_beat = expected_beats.pop_front();
                compare_field("payload_valid", {7'd0, oldest_beat.payload_valid},
                              {7'd0, m_payload_valid});
                compare_field("payload_byte", oldest_beat.payload_byte, m_payload_byte);
                compare_field("finished", {7'd0, oldest_beat.finished},
                              {7'd0, m_finished});
                compare_field("succeeded", {7'd0, oldest_beat.succeeded},
                              {7'd0, m_succeeded});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("http_response_body_deframer_core: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_requests_while_idle();
        test_minimal_chunked();
        test_disconnect_and_timeout();
        test_fixed_length_bodies();
        test_chunked_bodies();
        test_idle_timeouts();
        test_mixed_traffic();

        wait_drained();
        if (mismatches == 0) begin
            $display("http_response_body_deframer_core: match");
        end else begin
            $display("http_response_body_deframer_core: mismatch");
        end
        $finish;
    end

endmodule
